### rtl/core/blva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery low-voltage alarm package
// Shared widths, status codes, register indexes, the register set type and its reset values.
// ----------------------------------------------------------------------------
package blva_pkg;

  localparam int unsigned SampleWidth   = 10;
  localparam int unsigned StatusWidth   = 2;
  localparam int unsigned DutyWidth     = 8;
  localparam int unsigned ReminderWidth = 16;
  localparam int unsigned HalfWidth     = 12;
  localparam int unsigned BeepWidth     = 4;
  localparam int unsigned ToneWidth     = 16;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  // Battery status codes
  localparam logic [StatusWidth-1:0] StatusOk       = 2'd0;
  localparam logic [StatusWidth-1:0] StatusWarn     = 2'd1;
  localparam logic [StatusWidth-1:0] StatusShutdown = 2'd2;

  // Register indexes
  localparam logic [CfgIndexWidth-1:0] RegWarnLevel     = 3'd0;
  localparam logic [CfgIndexWidth-1:0] RegShutdownLevel = 3'd1;
  localparam logic [CfgIndexWidth-1:0] RegReminder      = 3'd2;
  localparam logic [CfgIndexWidth-1:0] RegHalfPeriod    = 3'd3;
  localparam logic [CfgIndexWidth-1:0] RegBeeps         = 3'd4;
  localparam logic [CfgIndexWidth-1:0] RegWarnDuty      = 3'd5;
  localparam logic [CfgIndexWidth-1:0] RegShutdownDuty  = 3'd6;
  localparam logic [CfgIndexWidth-1:0] RegToneTicks     = 3'd7;

  typedef struct packed {
    logic [SampleWidth-1:0]   warn_level_counts;
    logic [SampleWidth-1:0]   shutdown_level_counts;
    logic [ReminderWidth-1:0] reminder_ticks;
    logic [HalfWidth-1:0]     half_period_ticks;
    logic [BeepWidth-1:0]     beeps_per_train;
    logic [DutyWidth-1:0]     warn_duty;
    logic [DutyWidth-1:0]     shutdown_duty;
    logic [ToneWidth-1:0]     shutdown_tone_ticks;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    warn_level_counts:     10'd477,
    shutdown_level_counts: 10'd436,
    reminder_ticks:        16'd30000,
    half_period_ticks:     12'd500,
    beeps_per_train:       4'd4,
    warn_duty:             8'd200,
    shutdown_duty:         8'd255,
    shutdown_tone_ticks:   16'd6000
  };

endpackage

### rtl/core/battery_low_voltage_alarm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery low-voltage alarm
// Per-tick battery classification with warning beep trains and a shutdown
// tone. One ADC sample in, one status and buzzer duty out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, adc_sample): one beat per ms tick.
//   Output channel (out_valid/out_ready, battery_status, buzzer_level):
//   one result beat per input beat, in order.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always
//   ready; write registers only while no tick is in flight.
//   Path: an accepted sample is held in the input register, then the tick
//   engine feeds its result into the result register.
//   Throughput: one tick per cycle while the output does not stall; the
//   state update between the input and result registers is combinational.
//   Reset: all alarm state clears, registers return to their defaults,
//   both data registers empty.
//   Stall: while a result waits on out_ready the input register keeps one
//   more sample; after that in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module battery_low_voltage_alarm (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [blva_pkg::SampleWidth-1:0]    adc_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [blva_pkg::StatusWidth-1:0]    battery_status,
  output logic [blva_pkg::DutyWidth-1:0]      buzzer_level,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [blva_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [blva_pkg::CfgDataWidth-1:0]   cfg_data
);
  import blva_pkg::*;

  cfg_t                   cfg;
  logic                   sample_valid;
  logic [SampleWidth-1:0] sample;
  logic                   advance;
  logic [StatusWidth-1:0] tick_status;
  logic [DutyWidth-1:0]   tick_level;

  assign cfg_ready = 1'b1;

  blva_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Move a sample into the engine whenever the result slot frees up
  assign advance  = sample_valid & (~out_valid | out_ready);
  assign in_ready = ~sample_valid | advance;

  // Hold the accepted input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (in_ready) begin
      sample_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample <= adc_sample;
    end
  end

  blva_core u_core (
    .clk    (clk),
    .rst    (rst),
    .tick   (advance),
    .sample (sample),
    .cfg    (cfg),
    .status (tick_status),
    .level  (tick_level)
  );

  // Result register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      battery_status <= tick_status;
      buzzer_level   <= tick_level;
    end
  end

`ifndef SYNTH
  a_advance_loads_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("tick advanced but no result was loaded");

  a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while both registers are full and stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (battery_status == StatusOk || battery_status == StatusWarn ||
                   battery_status == StatusShutdown))
    else $error("result carries an unused status code");

  a_shutdown_level: assert property (@(posedge clk) disable iff (rst)
    (advance && tick_status == StatusShutdown) |->
      (tick_level == cfg.shutdown_duty || tick_level == '0))
    else $error("beep duty driven while in shutdown");

  a_warn_level: assert property (@(posedge clk) disable iff (rst)
    (advance && tick_status != StatusShutdown) |->
      (tick_level == cfg.warn_duty || tick_level == '0))
    else $error("tone duty driven outside shutdown");
`endif

endmodule

### rtl/core/blva_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm register file
// Holds the thresholds, timings and duties; one register written per beat.
// ----------------------------------------------------------------------------
module blva_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [blva_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [blva_pkg::CfgDataWidth-1:0]   cfg_data,
  output blva_pkg::cfg_t                      cfg
);
  import blva_pkg::*;

  // Write the addressed register, truncating data to its width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CfgReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegWarnLevel:     cfg.warn_level_counts     <= cfg_data[SampleWidth-1:0];
        RegShutdownLevel: cfg.shutdown_level_counts <= cfg_data[SampleWidth-1:0];
        RegReminder:      cfg.reminder_ticks        <= cfg_data[ReminderWidth-1:0];
        RegHalfPeriod:    cfg.half_period_ticks     <= cfg_data[HalfWidth-1:0];
        RegBeeps:         cfg.beeps_per_train       <= cfg_data[BeepWidth-1:0];
        RegWarnDuty:      cfg.warn_duty             <= cfg_data[DutyWidth-1:0];
        RegShutdownDuty:  cfg.shutdown_duty         <= cfg_data[DutyWidth-1:0];
        RegToneTicks:     cfg.shutdown_tone_ticks   <= cfg_data[ToneWidth-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/blva_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm tick engine
// Classifies one sample, advances the beep train and shutdown tone state,
// and produces the status and buzzer duty for that tick.
// ----------------------------------------------------------------------------
module blva_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              tick,
  input  logic [blva_pkg::SampleWidth-1:0]  sample,
  input  blva_pkg::cfg_t                    cfg,
  output logic [blva_pkg::StatusWidth-1:0]  status,
  output logic [blva_pkg::DutyWidth-1:0]    level
);
  import blva_pkg::*;

  logic [ReminderWidth-1:0] reminder_elapsed, reminder_elapsed_next;
  logic                     train_active, train_active_next;
  logic                     beep_on, beep_on_next;
  logic [BeepWidth-1:0]     beeps_done, beeps_done_next;
  logic [HalfWidth-1:0]     toggle_elapsed, toggle_elapsed_next;
  logic                     tone_active, tone_active_next;
  logic [ToneWidth-1:0]     tone_elapsed, tone_elapsed_next;
  logic                     was_shutdown, was_shutdown_next;
  logic                     is_shut;
  logic                     tone_now;

  // Classify the sample; shutdown wins over warning
  always_comb begin
    priority if (sample <= cfg.shutdown_level_counts) begin
      status = StatusShutdown;
    end else if (sample <= cfg.warn_level_counts) begin
      status = StatusWarn;
    end else begin
      status = StatusOk;
    end
  end

  assign is_shut = (status == StatusShutdown);

  // Next state for one tick
  always_comb begin
    reminder_elapsed_next = reminder_elapsed;
    train_active_next     = train_active;
    beep_on_next          = beep_on;
    beeps_done_next       = beeps_done;
    toggle_elapsed_next   = toggle_elapsed;
    tone_active_next      = tone_active;
    tone_elapsed_next     = tone_elapsed;
    tone_now              = 1'b0;

    // Shutdown entry starts the tone and cancels the train; exit drops the tone
    if (is_shut) begin
      if (!was_shutdown) begin
        tone_active_next    = 1'b1;
        tone_elapsed_next   = '0;
        train_active_next   = 1'b0;
        beep_on_next        = 1'b0;
        beeps_done_next     = '0;
        toggle_elapsed_next = '0;
      end
    end else begin
      tone_active_next  = 1'b0;
      tone_elapsed_next = '0;
    end
    was_shutdown_next = is_shut;

    // Saturating reminder counter
    if (reminder_elapsed != '1) begin
      reminder_elapsed_next = reminder_elapsed + 1'b1;
    end

    // Start a train or advance the running one
    if (status == StatusWarn && reminder_elapsed_next >= cfg.reminder_ticks) begin
      train_active_next     = 1'b1;
      beep_on_next          = 1'b1;
      beeps_done_next       = '0;
      toggle_elapsed_next   = '0;
      reminder_elapsed_next = '0;
    end else if (train_active_next) begin
      if (toggle_elapsed_next != '1) begin
        toggle_elapsed_next = toggle_elapsed_next + 1'b1;
      end
      if (toggle_elapsed_next >= cfg.half_period_ticks) begin
        toggle_elapsed_next = '0;
        if (!beep_on_next) begin
          beep_on_next = 1'b1;
        end else begin
          beep_on_next    = 1'b0;
          beeps_done_next = beeps_done_next + 1'b1;
          if (beeps_done_next >= cfg.beeps_per_train) begin
            train_active_next = 1'b0;
            beeps_done_next   = '0;
          end
        end
      end
    end

    // Time the shutdown tone
    if (tone_active_next) begin
      if (tone_elapsed_next < cfg.shutdown_tone_ticks) begin
        tone_elapsed_next = tone_elapsed_next + 1'b1;
        tone_now          = 1'b1;
      end else begin
        tone_active_next = 1'b0;
      end
    end
  end

  // Drive the buzzer: tone first, then an audible beep
  always_comb begin
    priority if (tone_now) begin
      level = cfg.shutdown_duty;
    end else if (train_active_next && beep_on_next) begin
      level = cfg.warn_duty;
    end else begin
      level = '0;
    end
  end

  // Commit the state on each tick
  always_ff @(posedge clk) begin
    if (rst) begin
      reminder_elapsed <= '0;
      train_active     <= 1'b0;
      beep_on          <= 1'b0;
      beeps_done       <= '0;
      toggle_elapsed   <= '0;
      tone_active      <= 1'b0;
      tone_elapsed     <= '0;
      was_shutdown     <= 1'b0;
    end else if (tick) begin
      reminder_elapsed <= reminder_elapsed_next;
      train_active     <= train_active_next;
      beep_on          <= beep_on_next;
      beeps_done       <= beeps_done_next;
      toggle_elapsed   <= toggle_elapsed_next;
      tone_active      <= tone_active_next;
      tone_elapsed     <= tone_elapsed_next;
      was_shutdown     <= was_shutdown_next;
    end
  end

endmodule

### tb/battery_low_voltage_alarm_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery low-voltage alarm testbench
// Streams ADC sample beats through the alarm under random input gaps and
// output stalls, and reprograms the register set between phases. Expected
// status and buzzer duty come from a cycle-free model of the classifier,
// beep train and shutdown tone, and every result beat is checked in order.
// ----------------------------------------------------------------------------
module battery_low_voltage_alarm_tb;
  import blva_pkg::*;

  localparam int unsigned StuckLimit   = 2000;
  localparam int unsigned PhaseCount   = 14;
  localparam int unsigned BeatsPerPhase = 118;

  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [DutyWidth-1:0]   level;
  } tick_result_t;

  // Alarm model and in-order store of expected result beats
  class alarm_scoreboard;
    cfg_t                     cfg;
    logic [ReminderWidth-1:0] since_train;
    bit                       train_on;
    bit                       beep_high;
    logic [BeepWidth-1:0]     beep_count;
    logic [HalfWidth-1:0]     half_count;
    bit                       tone_on;
    logic [ToneWidth-1:0]     tone_count;
    bit                       in_shutdown;
    tick_result_t             expected_ticks[$];
    int                       errors;

    function new();
      cfg         = CfgReset;
      since_train = '0;
      train_on    = 1'b0;
      beep_high   = 1'b0;
      beep_count  = '0;
      half_count  = '0;
      tone_on     = 1'b0;
      tone_count  = '0;
      in_shutdown = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        RegWarnLevel:     cfg.warn_level_counts     = data[SampleWidth-1:0];
        RegShutdownLevel: cfg.shutdown_level_counts = data[SampleWidth-1:0];
        RegReminder:      cfg.reminder_ticks        = data[ReminderWidth-1:0];
        RegHalfPeriod:    cfg.half_period_ticks     = data[HalfWidth-1:0];
        RegBeeps:         cfg.beeps_per_train       = data[BeepWidth-1:0];
        RegWarnDuty:      cfg.warn_duty             = data[DutyWidth-1:0];
        RegShutdownDuty:  cfg.shutdown_duty         = data[DutyWidth-1:0];
        RegToneTicks:     cfg.shutdown_tone_ticks   = data[ToneWidth-1:0];
        default: ;
      endcase
    endfunction

    // Advance a running beep train by one tick
    function void step_train();
      if (half_count != '1) half_count++;
      if (half_count < cfg.half_period_ticks) return;
      half_count = '0;
      if (!beep_high) begin
        beep_high = 1'b1;
        return;
      end
      beep_high = 1'b0;
      beep_count++;
      if (beep_count >= cfg.beeps_per_train) begin
        train_on   = 1'b0;
        beep_count = '0;
      end
    endfunction

    // Work out the result of one accepted sample beat
    function void note_sample(logic [SampleWidth-1:0] sample);
      tick_result_t           r;
      bit                     tone_now;
      logic [StatusWidth-1:0] status;
      tone_now = 1'b0;
      if (sample <= cfg.shutdown_level_counts) status = StatusShutdown;
      else if (sample <= cfg.warn_level_counts) status = StatusWarn;
      else status = StatusOk;

      // Start the tone on shutdown entry, drop it on exit
      if (status == StatusShutdown) begin
        if (!in_shutdown) begin
          tone_on    = 1'b1;
          tone_count = '0;
          train_on   = 1'b0;
          beep_high  = 1'b0;
          beep_count = '0;
          half_count = '0;
        end
      end else begin
        tone_on    = 1'b0;
        tone_count = '0;
      end
      in_shutdown = (status == StatusShutdown);

      if (since_train != '1) since_train++;
      if (status == StatusWarn && since_train >= cfg.reminder_ticks) begin
        train_on    = 1'b1;
        beep_high   = 1'b1;
        beep_count  = '0;
        half_count  = '0;
        since_train = '0;
      end else if (train_on) begin
        step_train();
      end

      if (tone_on) begin
        if (tone_count < cfg.shutdown_tone_ticks) begin
          tone_count++;
          tone_now = 1'b1;
        end else begin
          tone_on = 1'b0;
        end
      end

      r.status = status;
      if (tone_now) r.level = cfg.shutdown_duty;
      else if (train_on && beep_high) r.level = cfg.warn_duty;
      else r.level = '0;
      expected_ticks.push_back(r);
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_result(logic [StatusWidth-1:0] status, logic [DutyWidth-1:0] level);
      tick_result_t r;
      if (expected_ticks.size() == 0) begin
        $display("%0t: unexpected result beat, status %0d level %0d", $time, status, level);
        errors++;
        return;
      end
      r = expected_ticks.pop_front();
      if (status !== r.status) begin
        $display("%0t: battery_status expected %0d actual %0d", $time, r.status, status);
        errors++;
      end
      if (level !== r.level) begin
        $display("%0t: buzzer_level expected %0d actual %0d", $time, r.level, level);
        errors++;
      end
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction
  endclass

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [SampleWidth-1:0]   adc_sample = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [StatusWidth-1:0]   battery_status;
  logic [DutyWidth-1:0]     buzzer_level;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data  = '0;

  alarm_scoreboard board;
  int                gap_pct   = 0;
  int                stall_pct = 0;
  int                stall_left = 0;
  int unsigned       stuck_cycles = 0;

  battery_low_voltage_alarm uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .adc_sample     (adc_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .battery_status (battery_status),
    .buzzer_level   (buzzer_level),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #4 clk = ~clk;

  // Check result beats and stall the output in random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) board.check_result(battery_status, buzzer_level);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(99, 0) < stall_pct) begin
        stall_left = $urandom_range(9, 0);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Abort when no channel moves a beat for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= StuckLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Send one sample beat, with an optional gap ahead of it
  task automatic send_sample(input logic [SampleWidth-1:0] sample);
    if (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    adc_sample <= sample;
    do @(posedge clk); while (!in_ready);
    board.note_sample(sample);
  endtask

  // Drop valid and wait for every expected result beat
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
  endtask

  // Program the whole register set, with random junk above the field widths
  task automatic load_settings(input cfg_t s);
    logic [CfgDataWidth-1:0] junk;
    junk = ($urandom_range(3, 0) == 0) ? CfgDataWidth'($urandom) : '0;
    write_reg(RegWarnLevel,     {junk[15:10], s.warn_level_counts});
    write_reg(RegShutdownLevel, {junk[15:10], s.shutdown_level_counts});
    write_reg(RegReminder,      s.reminder_ticks);
    write_reg(RegHalfPeriod,    {junk[15:12], s.half_period_ticks});
    write_reg(RegBeeps,         {junk[15:4], s.beeps_per_train});
    write_reg(RegWarnDuty,      {junk[15:8], s.warn_duty});
    write_reg(RegShutdownDuty,  {junk[15:8], s.shutdown_duty});
    write_reg(RegToneTicks,     s.shutdown_tone_ticks);
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    int   shut;
    int   warn;
    shut = $urandom_range(700, 0);
    warn = shut + $urandom_range(300, 0);
    if (warn > 1023) warn = 1023;
    if ($urandom_range(5, 0) == 0) begin
      shut = $urandom_range(1023, 0);
      warn = $urandom_range(1023, 0);
    end
    s.shutdown_level_counts = SampleWidth'(shut);
    s.warn_level_counts     = SampleWidth'(warn);
    case ($urandom_range(7, 0))
      0:       s.reminder_ticks = '0;
      1:       s.reminder_ticks = '1;
      default: s.reminder_ticks = ReminderWidth'($urandom_range(40, 1));
    endcase
    case ($urandom_range(7, 0))
      0:       s.half_period_ticks = '0;
      1:       s.half_period_ticks = '1;
      default: s.half_period_ticks = HalfWidth'($urandom_range(6, 1));
    endcase
    s.beeps_per_train = BeepWidth'($urandom);
    s.warn_duty       = DutyWidth'($urandom);
    s.shutdown_duty   = DutyWidth'($urandom);
    case ($urandom_range(7, 0))
      0:       s.shutdown_tone_ticks = '0;
      1:       s.shutdown_tone_ticks = '1;
      default: s.shutdown_tone_ticks = ToneWidth'($urandom_range(25, 1));
    endcase
    return s;
  endfunction

  // Pick a sample that lands in the wanted status band where one exists
  function automatic logic [SampleWidth-1:0] pick_sample(input logic [StatusWidth-1:0] want);
    int shut;
    int warn;
    shut = board.cfg.shutdown_level_counts;
    warn = board.cfg.warn_level_counts;
    if (want == StatusShutdown) return SampleWidth'($urandom_range(shut, 0));
    if (want == StatusWarn && warn > shut) return SampleWidth'($urandom_range(warn, shut + 1));
    if (want == StatusOk && warn < 1023 && shut < 1023)
      return SampleWidth'($urandom_range(1023, ((warn > shut) ? warn : shut) + 1));
    return SampleWidth'($urandom);
  endfunction

  initial begin
    cfg_t                   s;
    logic [StatusWidth-1:0] want;
    int                     left;
    int                     run;
    int                     r;

    board = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes and both thresholds at the default settings
    send_sample(10'd1023);
    send_sample(10'd478);
    send_sample(10'd477);
    send_sample(10'd437);
    send_sample(10'd436);
    send_sample(10'd0);
    send_sample(10'd0);
    send_sample(10'h155);
    send_sample(10'h2AA);
    send_sample(10'd1023);

    // Directed: zero reminder, zero half period, zero beeps, zero tone length
    settle();
    s = '{warn_level_counts: 10'd600, shutdown_level_counts: 10'd300,
          reminder_ticks: '0, half_period_ticks: '0, beeps_per_train: '0,
          warn_duty: 8'd170, shutdown_duty: 8'd85, shutdown_tone_ticks: '0};
    load_settings(s);
    send_sample(10'd500);
    send_sample(10'd500);
    send_sample(10'd500);
    send_sample(10'd200);
    send_sample(10'd200);
    send_sample(10'd1023);
    send_sample(10'd500);

    // Directed: shutdown level above the warning level
    settle();
    s.warn_level_counts     = 10'd100;
    s.shutdown_level_counts = 10'd700;
    s.shutdown_tone_ticks   = 16'd3;
    load_settings(s);
    send_sample(10'd400);
    send_sample(10'd50);

    // Random phases: first all maximum, then all minimum, then mixed settings
    for (int phase = 0; phase < PhaseCount; phase++) begin
      settle();
      if (phase == 0) begin
        s = '{warn_level_counts: '1, shutdown_level_counts: '1, reminder_ticks: '1,
              half_period_ticks: '1, beeps_per_train: '1, warn_duty: '1,
              shutdown_duty: '1, shutdown_tone_ticks: '1};
      end else if (phase == 1) begin
        s = '0;
      end else begin
        s = random_settings();
      end
      load_settings(s);
      if (phase == PhaseCount - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        r = $urandom_range(2, 0);
        gap_pct   = (r == 0) ? 0 : (r == 1) ? 15 : 40;
        r = $urandom_range(2, 0);
        stall_pct = (r == 0) ? 0 : (r == 1) ? 15 : 40;
      end
      left = BeatsPerPhase;
      while (left > 0) begin
        // Hold one status band for a run so trains and tones play out
        r = $urandom_range(9, 0);
        want = (r < 5) ? StatusWarn : (r < 8) ? StatusOk : StatusShutdown;
        run = $urandom_range(30, 1);
        for (int j = 0; j < run && left > 0; j++) begin
          if ($urandom_range(9, 0) == 0) send_sample(SampleWidth'($urandom));
          else send_sample(pick_sample(want));
          left--;
        end
      end
    end

    // Drain and report
    settle();
    repeat (4) @(posedge clk);
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
